// File: design/assert_macros.svh
// assertion macros shared by the sector cache tag controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked on every rising clock edge outside reset
`define SCLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked on every rising clock edge, reset included
`define SCLT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCLT_ASSERT(lbl, prop, msg)
`define SCLT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: design/sclt_pkg.sv
// shared types and constants of the sector cache tag controller
package sclt_pkg;

    localparam logic [15:0] MAX_SECTOR = 16'd4096;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_INV_DEV = 2'd2,
        CMD_INV_ALL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ARG = 2'd1,
        ST_DEV_ERR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CTRL_IDLE,
        CTRL_CHECK,
        CTRL_SCAN,
        CTRL_COMMIT,
        CTRL_DONE
    } ctrl_state_t;

    // search token walking along the row of tag cells
    typedef struct packed {
        logic        vld;
        logic [3:0]  dev;
        logic [47:0] blk;
        logic        found;
        logic        inv_found;
        logic [63:0] best_age;
    } scan_pkt_t;

    // update broadcast to every cell
    typedef struct packed {
        logic        install;
        logic        inv_all;
        logic        inv_dev;
        logic [3:0]  dev;
        logic [47:0] blk;
        logic [63:0] age;
    } upd_t;

endpackage

// File: design/sector_cache_lru_tags.sv
// top level of the sector cache tag and lru replacement controller
//
// channel   dir  signals                                 fields (lowest bit up)
// s_axis    in   tvalid tready tuser[1:0] tdata[71:0]    tuser: cmd
//                                                        tdata: device_id, lba,
//                                                        sector_bytes, device_ok
// m_axis    out  tvalid tready tdata[79:0]               status, hit, slot,
//                                                        fill_request, write_through,
//                                                        hit_count, miss_count
//
// one request at a time; a read or write that passes the checks is looked up by
// the search token, which walks one cell per cycle along the row of ENTRIES tag
// cells; invalidates skip the search and go through commit, rejected sizes and
// failed writes go from check straight to done
// a finished result sits in the output register, so the next request is
// taken while it waits; the block only stalls when a second result is ready
// and the first has still not been taken
// reset clears all entry valid bits, the use clock and both counters at once
`include "assert_macros.svh"

module sector_cache_lru_tags
    import sclt_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // cmd
    input  logic [71:0] s_axis_tdata,   // device_id, lba, sector_bytes, device_ok, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // status, hit, slot, fill_request,
                                        // write_through, hit_count, miss_count, zero pad
);

    localparam int IW = $clog2(ENTRIES);

    // control state
    ctrl_state_t   state_reg, state_next;
    logic [63:0]   use_clock_reg;
    logic [31:0]   hits_reg;
    logic [31:0]   misses_reg;
    logic          out_valid_reg;

    // request held for the whole operation
    cmd_t          cmd_reg;
    logic [3:0]    dev_reg;
    logic [47:0]   lba_reg;
    logic [15:0]   size_reg;
    logic          ok_reg;

    // result being assembled
    status_t       status_res_reg;
    logic          hit_res_reg;
    logic [IW-1:0] slot_res_reg;
    logic          fill_res_reg;
    logic          wthru_res_reg;
    logic          do_install_reg;
    logic          hit_inc_reg;
    logic          miss_inc_reg;

    // output register
    status_t       out_status_reg;
    logic          out_hit_reg;
    logic [3:0]    out_slot_reg;
    logic          out_fill_reg;
    logic          out_wthru_reg;
    logic [31:0]   out_hits_reg;
    logic [31:0]   out_misses_reg;

    // fsm outputs
    logic          accept;
    logic          launch;
    logic          out_load;
    upd_t          upd;

    // cell row
    scan_pkt_t     pkt_chain [ENTRIES+1];
    logic [IW-1:0] match_chain [ENTRIES+1];
    logic [IW-1:0] inv_chain [ENTRIES+1];
    logic [IW-1:0] best_chain [ENTRIES+1];
    logic [ENTRIES:0] tok_vec;

    logic          bad_size;
    logic          tail_vld;
    scan_pkt_t     tail_pkt;
    logic [IW-1:0] chosen_idx;
    logic [IW+3:0] slot_wide;

    assign bad_size = (size_reg == 16'd0) || (size_reg > MAX_SECTOR);
    assign tail_pkt = pkt_chain[ENTRIES];
    assign tail_vld = tail_pkt.vld;

    // hit slot first, then first free slot, then the oldest entry
    always_comb
    begin
        priority if (tail_pkt.found)
        begin
            chosen_idx = match_chain[ENTRIES];
        end
        else if (tail_pkt.inv_found)
        begin
            chosen_idx = inv_chain[ENTRIES];
        end
        else
        begin
            chosen_idx = best_chain[ENTRIES];
        end
    end

    // token launched into the first cell
    assign pkt_chain[0].vld       = launch;
    assign pkt_chain[0].dev       = dev_reg;
    assign pkt_chain[0].blk       = lba_reg;
    assign pkt_chain[0].found     = 1'b0;
    assign pkt_chain[0].inv_found = 1'b0;
    assign pkt_chain[0].best_age  = '1;
    assign match_chain[0]         = '0;
    assign inv_chain[0]           = '0;
    assign best_chain[0]          = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            sclt_cell #(
                .IDX (g),
                .IW  (IW)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .pkt_in        (pkt_chain[g]),
                .match_idx_in  (match_chain[g]),
                .inv_idx_in    (inv_chain[g]),
                .best_idx_in   (best_chain[g]),
                .pkt_out       (pkt_chain[g+1]),
                .match_idx_out (match_chain[g+1]),
                .inv_idx_out   (inv_chain[g+1]),
                .best_idx_out  (best_chain[g+1]),
                .upd           (upd),
                .upd_idx       (slot_res_reg)
            );
        end
        for (g = 0; g <= ENTRIES; g++)
        begin : g_tok
            assign tok_vec[g] = pkt_chain[g].vld;
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = CTRL_CHECK;
                end
            end
            CTRL_CHECK:
            begin
                priority if (cmd_reg == CMD_INV_DEV || cmd_reg == CMD_INV_ALL)
                begin
                    state_next = CTRL_COMMIT;
                end
                else if (bad_size || (cmd_reg == CMD_WRITE && !ok_reg))
                begin
                    state_next = CTRL_DONE;
                end
                else
                begin
                    state_next = CTRL_SCAN;
                end
            end
            CTRL_SCAN:
            begin
                if (tail_vld)
                begin
                    state_next = CTRL_COMMIT;
                end
            end
            CTRL_COMMIT:
            begin
                state_next = CTRL_DONE;
            end
            CTRL_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        launch        = 1'b0;
        out_load      = 1'b0;
        upd.install   = 1'b0;
        upd.inv_all   = 1'b0;
        upd.inv_dev   = 1'b0;
        upd.dev       = dev_reg;
        upd.blk       = lba_reg;
        upd.age       = use_clock_reg + 64'd1;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            CTRL_CHECK:
            begin
                launch = (cmd_reg == CMD_READ || cmd_reg == CMD_WRITE)
                         && !bad_size && !(cmd_reg == CMD_WRITE && !ok_reg);
            end
            CTRL_SCAN:
            begin
            end
            CTRL_COMMIT:
            begin
                upd.install = do_install_reg;
                upd.inv_all = (cmd_reg == CMD_INV_ALL);
                upd.inv_dev = (cmd_reg == CMD_INV_DEV);
            end
            CTRL_DONE:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // control registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTRL_IDLE;
            use_clock_reg <= 64'd0;
            hits_reg      <= 32'd0;
            misses_reg    <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CTRL_COMMIT)
            begin
                if (do_install_reg)
                begin
                    use_clock_reg <= use_clock_reg + 64'd1;
                end
                if (hit_inc_reg)
                begin
                    hits_reg <= hits_reg + 32'd1;
                end
                if (miss_inc_reg)
                begin
                    misses_reg <= misses_reg + 32'd1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request, result and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(s_axis_tuser);
            dev_reg  <= s_axis_tdata[3:0];
            lba_reg  <= s_axis_tdata[51:4];
            size_reg <= s_axis_tdata[67:52];
            ok_reg   <= s_axis_tdata[68];
        end
        if (state_reg == CTRL_CHECK)
        begin
            status_res_reg <= ST_OK;
            hit_res_reg    <= 1'b0;
            slot_res_reg   <= '0;
            fill_res_reg   <= 1'b0;
            wthru_res_reg  <= 1'b0;
            do_install_reg <= 1'b0;
            hit_inc_reg    <= 1'b0;
            miss_inc_reg   <= 1'b0;
            if (cmd_reg == CMD_READ || cmd_reg == CMD_WRITE)
            begin
                priority if (bad_size)
                begin
                    status_res_reg <= ST_BAD_ARG;
                end
                else if (cmd_reg == CMD_WRITE && !ok_reg)
                begin
                    // failed write-through: no lookup, tags untouched
                    status_res_reg <= ST_DEV_ERR;
                    wthru_res_reg  <= 1'b1;
                end
                else
                begin
                end
            end
        end
        if (state_reg == CTRL_SCAN && tail_vld)
        begin
            hit_res_reg  <= tail_pkt.found;
            slot_res_reg <= chosen_idx;
            if (cmd_reg == CMD_WRITE)
            begin
                wthru_res_reg  <= 1'b1;
                do_install_reg <= 1'b1;
            end
            else if (tail_pkt.found)
            begin
                // read hit only refreshes the age
                do_install_reg <= 1'b1;
                hit_inc_reg    <= 1'b1;
            end
            else
            begin
                fill_res_reg <= 1'b1;
                if (ok_reg)
                begin
                    do_install_reg <= 1'b1;
                    miss_inc_reg   <= 1'b1;
                end
                else
                begin
                    status_res_reg <= ST_DEV_ERR;
                end
            end
        end
        if (out_load)
        begin
            out_status_reg <= status_res_reg;
            out_hit_reg    <= hit_res_reg;
            out_slot_reg   <= slot_wide[3:0];
            out_fill_reg   <= fill_res_reg;
            out_wthru_reg  <= wthru_res_reg;
            out_hits_reg   <= hits_reg;
            out_misses_reg <= misses_reg;
        end
    end

    // slot field carries the low four bits of the index
    assign slot_wide = {4'd0, slot_res_reg};

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_misses_reg, out_hits_reg, out_wthru_reg,
                            out_fill_reg, out_slot_reg, out_hit_reg, out_status_reg};

    // at most one search token in the row
    `SCLT_ASSERT(a_one_token, $onehot0(tok_vec), "more than one search token in flight")
    // a token only leaves the row while the controller waits for it
    `SCLT_ASSERT(a_tail_in_scan, tail_vld |-> (state_reg == CTRL_SCAN), "stray search result")
    // install and invalidate never share a cycle
    `SCLT_ASSERT(a_upd_excl, upd.install |-> !(upd.inv_all || upd.inv_dev), "install during invalidate")
    // a loaded result is presented on the next cycle
    `SCLT_ASSERT(a_load_shows, out_load |=> m_axis_tvalid, "loaded result not presented")
    // no result straight out of reset
    `SCLT_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

// File: design/sclt_cell.sv
// one tag cell: holds a single entry and passes the search token on
module sclt_cell
    import sclt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  scan_pkt_t       pkt_in,
    input  logic [IW-1:0]   match_idx_in,
    input  logic [IW-1:0]   inv_idx_in,
    input  logic [IW-1:0]   best_idx_in,
    output scan_pkt_t       pkt_out,
    output logic [IW-1:0]   match_idx_out,
    output logic [IW-1:0]   inv_idx_out,
    output logic [IW-1:0]   best_idx_out,
    input  upd_t            upd,
    input  logic [IW-1:0]   upd_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic          valid_reg;
    logic [3:0]    dev_reg;
    logic [47:0]   blk_reg;
    logic [63:0]   age_reg;

    logic          tok_vld_reg;
    scan_pkt_t     pkt_reg;
    scan_pkt_t     pkt_next;
    logic [IW-1:0] match_idx_reg, match_idx_next;
    logic [IW-1:0] inv_idx_reg, inv_idx_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;

    logic          hit_here;
    logic          inv_here;
    logic          old_here;

    assign hit_here = valid_reg && !pkt_in.found
                      && (dev_reg == pkt_in.dev) && (blk_reg == pkt_in.blk);
    assign inv_here = !valid_reg && !pkt_in.inv_found;
    assign old_here = valid_reg && (age_reg < pkt_in.best_age);

    always_comb
    begin
        pkt_next       = pkt_in;
        match_idx_next = match_idx_in;
        inv_idx_next   = inv_idx_in;
        best_idx_next  = best_idx_in;
        if (hit_here)
        begin
            pkt_next.found = 1'b1;
            match_idx_next = MY_IDX;
        end
        if (inv_here)
        begin
            pkt_next.inv_found = 1'b1;
            inv_idx_next       = MY_IDX;
        end
        if (old_here)
        begin
            pkt_next.best_age = age_reg;
            best_idx_next     = MY_IDX;
        end
    end

    // token valid and entry valid are control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_vld_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            tok_vld_reg <= pkt_in.vld;
            if (upd.install && (upd_idx == MY_IDX))
            begin
                valid_reg <= 1'b1;
            end
            else if (upd.inv_all || (upd.inv_dev && (dev_reg == upd.dev)))
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg       <= pkt_next;
        match_idx_reg <= match_idx_next;
        inv_idx_reg   <= inv_idx_next;
        best_idx_reg  <= best_idx_next;
        if (upd.install && (upd_idx == MY_IDX))
        begin
            dev_reg <= upd.dev;
            blk_reg <= upd.blk;
            age_reg <= upd.age;
        end
    end

    // token valid comes from the reset register
    always_comb
    begin
        pkt_out     = pkt_reg;
        pkt_out.vld = tok_vld_reg;
    end

    assign match_idx_out = match_idx_reg;
    assign inv_idx_out   = inv_idx_reg;
    assign best_idx_out  = best_idx_reg;

endmodule
